FILE: sv/dbpq_pkg.sv
// Shared types and constants for the divisor-ranked priority queue.
// No dependencies; the top module refers to it by scoped names.
`default_nettype none
package dbpq_pkg;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int RULE_DEPTH_DEF  = 128;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    localparam logic KIND_POP   = 1'b0;
    localparam logic KIND_EVICT = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] in_value;
        logic [6:0]         rule_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [7:0]         out_rank;
        logic               result_kind;
        logic               queue_was_empty;
    } res_t;

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        magnitude = v[31] ? (32'd0 - v) : v;
    endfunction
endpackage
`default_nettype wire

FILE: sv/divisor_ranked_bounded_priority_queue_top.sv
// Divisor-ranked bounded priority queue: rule RAM, remainder unit, sorted queue.
// Load and pop leave busy low; a push holds busy while the rules are scanned in turn
// (read, check, then a remainder test for each nonzero rule) until a rule divides the
// value or the rules run out, each test done by the one-bit-per-cycle remainder unit.
// Results are registered, appearing in the cycle after they are formed; the receiver cannot stall.
// Reset clears the queue and rule_count; rule RAM contents are undefined.
`default_nettype none
module divisor_ranked_bounded_priority_queue_top #(
    parameter int QUEUE_DEPTH = dbpq_pkg::QUEUE_DEPTH_DEF,
    parameter int RULE_DEPTH  = dbpq_pkg::RULE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dbpq_pkg::req_t req,
    output logic               result_valid,
    output dbpq_pkg::res_t     result,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata
);
    localparam int RA = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int RW = $clog2(RULE_DEPTH + 1);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_INS  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  rule_count_reg;
    logic [8:0]  idx_reg, idx_next;
    logic [8:0]  limit;
    logic [RW-1:0] rank_reg, rank_next;
    logic [31:0] val_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   vals_reg [QUEUE_DEPTH];
    logic [RW-1:0] ranks_reg [QUEUE_DEPTH];
    logic          result_valid_next;
    dbpq_pkg::res_t result_next;

    logic        accept;
    logic        ram_we, ram_re;
    logic [31:0] ram_rdata;
    logic [31:0] rule_mag;
    logic        rem_start, rem_done, rem_zero;
    logic        full;
    logic [CW-1:0] n_keep;
    logic [CW-1:0] pos;
    logic [31:0]   sh_v [QUEUE_DEPTH];
    logic [RW-1:0] sh_r [QUEUE_DEPTH];
    logic [31:0]   ins_v [QUEUE_DEPTH];
    logic [RW-1:0] ins_r [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le_mask;
    logic [8:0] slot9;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign limit  = ({1'b0, rule_count_reg} > 9'(RULE_DEPTH)) ? 9'(RULE_DEPTH)
                                                              : {1'b0, rule_count_reg};
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign slot9  = {2'b00, req.rule_index};

    // Rule table: written by loads in idle, read one rule at a time during a push.
    // Busy holds off new requests while a scan runs, so reads and writes never overlap.
    assign ram_we = accept && (req.opcode == dbpq_pkg::OP_LOAD) && (slot9 < 9'(RULE_DEPTH));
    assign ram_re = (state_reg == ST_RD);

    dbpq_ram #(.WIDTH(32), .DEPTH(RULE_DEPTH)) u_rules (
        .clk   (clk),
        .we    (ram_we),
        .waddr (RA'(slot9)),
        .wdata (req.in_value),
        .re    (ram_re),
        .raddr (idx_reg[RA-1:0]),
        .rdata (ram_rdata)
    );

    assign rule_mag  = dbpq_pkg::magnitude(ram_rdata);
    assign rem_start = (state_reg == ST_CHK) && (rule_mag != 32'd0);

    dbpq_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (dbpq_pkg::magnitude(val_reg)),
        .divisor  (rule_mag),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    // Head removal when full: every entry takes its upper neighbor; the top slot clears.
    genvar j;
    generate
        for (j = 0; j < QUEUE_DEPTH; j++)
        begin : g_shift
            if (j + 1 < QUEUE_DEPTH)
            begin : g_mid
                assign sh_v[j] = full ? vals_reg[j+1] : vals_reg[j];
                assign sh_r[j] = full ? ranks_reg[j+1] : ranks_reg[j];
            end
            else
            begin : g_top
                assign sh_v[j] = full ? 32'd0 : vals_reg[j];
                assign sh_r[j] = full ? '0 : ranks_reg[j];
            end
            assign le_mask[j] = (CW'(j) < n_keep) && (sh_r[j] <= rank_reg);
            if (j == 0)
            begin : g_bot
                assign ins_v[j] = (pos == '0) ? val_reg : sh_v[j];
                assign ins_r[j] = (pos == '0) ? rank_reg : sh_r[j];
            end
            else
            begin : g_up
                assign ins_v[j] = (CW'(j) < pos) ? sh_v[j] :
                                  (CW'(j) == pos) ? val_reg : sh_v[j-1];
                assign ins_r[j] = (CW'(j) < pos) ? sh_r[j] :
                                  (CW'(j) == pos) ? rank_reg : sh_r[j-1];
            end
        end
    endgenerate

    // Entries are sorted, so the insert point is the count of ranks not above ours.
    assign n_keep = full ? (count_reg - CW'(1)) : count_reg;
    assign pos    = CW'($countones(le_mask));

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        rank_next         = rank_reg;
        count_next        = count_reg;
        result_valid_next = 1'b0;
        result_next       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.opcode == dbpq_pkg::OP_PUSH))
                begin
                    idx_next = '0;
                    if (limit == 9'd0)
                    begin
                        rank_next  = RW'(RULE_DEPTH);
                        state_next = ST_INS;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
                else if (accept && (req.opcode == dbpq_pkg::OP_POP))
                begin
                    result_valid_next       = 1'b1;
                    result_next.result_kind = dbpq_pkg::KIND_POP;
                    if (count_reg == '0)
                    begin
                        result_next.queue_was_empty = 1'b1;
                    end
                    else
                    begin
                        result_next.out_value = vals_reg[0];
                        result_next.out_rank  = 8'(ranks_reg[0]);
                        count_next            = count_reg - CW'(1);
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (rule_mag != 32'd0)
                begin
                    state_next = ST_DIV;
                end
                else if (idx_reg + 9'd1 == limit)
                begin
                    rank_next  = RW'(RULE_DEPTH);
                    state_next = ST_INS;
                end
                else
                begin
                    idx_next   = idx_reg + 9'd1;
                    state_next = ST_RD;
                end
            end
            ST_DIV:
            begin
                if (rem_done)
                begin
                    if (rem_zero)
                    begin
                        rank_next  = RW'(idx_reg);
                        state_next = ST_INS;
                    end
                    else if (idx_reg + 9'd1 == limit)
                    begin
                        rank_next  = RW'(RULE_DEPTH);
                        state_next = ST_INS;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 9'd1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_INS:
            begin
                state_next = ST_IDLE;
                count_next = n_keep + CW'(1);
                if (full)
                begin
                    result_valid_next       = 1'b1;
                    result_next.result_kind = dbpq_pkg::KIND_EVICT;
                    result_next.out_value   = vals_reg[0];
                    result_next.out_rank    = 8'(ranks_reg[0]);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rule_count_reg <= '0;
            count_reg      <= '0;
            result_valid   <= 1'b0;
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                vals_reg[k]  <= '0;
                ranks_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            result_valid <= result_valid_next;
            if (cfg_we)
            begin
                rule_count_reg <= cfg_wdata;
            end
            // Advance the queue on a nonempty pop; rewrite it on insert.
            if ((state_reg == ST_IDLE) && result_valid_next && (count_reg != '0))
            begin
                for (int k = 0; k < QUEUE_DEPTH; k++)
                begin
                    vals_reg[k]  <= (k + 1 < QUEUE_DEPTH) ? vals_reg[(k + 1) % QUEUE_DEPTH] : '0;
                    ranks_reg[k] <= (k + 1 < QUEUE_DEPTH) ? ranks_reg[(k + 1) % QUEUE_DEPTH]
                                                          : '0;
                end
            end
            else if (state_reg == ST_INS)
            begin
                for (int k = 0; k < QUEUE_DEPTH; k++)
                begin
                    vals_reg[k]  <= ins_v[k];
                    ranks_reg[k] <= ins_r[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        rank_reg <= rank_next;
        result   <= result_next;
        if (accept)
        begin
            val_reg <= req.in_value;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_evict_from_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind) |-> $past(state_reg == ST_INS && full))
        else $error("eviction without full insert");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.queue_was_empty) |-> $past(count_reg == '0))
        else $error("empty flag with entries present");

    a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> (state_reg == ST_DIV))
        else $error("remainder done outside divide wait");
endmodule
`default_nettype wire

FILE: sv/dbpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dbpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/dbpq_rem.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle, with done pulsing
// once all 32 quotient bits have been shifted through. Depends on nothing; reports only
// whether the remainder is zero.
`default_nettype none
module dbpq_rem (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic             rem_zero
);
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg;
    logic [31:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic [32:0] trial;

    always_comb
    begin
        trial    = {rem_reg[31:0], quo_reg[31]};
        rem_next = (trial >= {1'b0, div_reg}) ? (trial - {1'b0, div_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[30:0], 1'b0};
        end
    end

    assign rem_zero = (rem_reg == 33'd0);
endmodule
`default_nettype wire
